/* rtl/iere_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iere_pkg
// Shared types and constants of the input event record encoder: event modes,
// configuration register indexes, the record passed from front to back end,
// and the record queue geometry.
// ----------------------------------------------------------------------------
package iere_pkg;

    // Event modes on the input channel; codes 11 to 15 are ignored
    typedef enum logic [3:0] {
        MODE_ENABLE    = 4'd0,
        MODE_DISABLE   = 4'd1,
        MODE_PRESS     = 4'd2,
        MODE_RELEASE   = 4'd3,
        MODE_MOVE      = 4'd4,
        MODE_KEYDOWN   = 4'd5,
        MODE_KEYUP     = 4'd6,
        MODE_FOCUS_IN  = 4'd7,
        MODE_FOCUS_OUT = 4'd8,
        MODE_ENTER     = 4'd9,
        MODE_EXIT      = 4'd10
    } t_mode;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_AREA_WIDTH    = 2'd0,
        CFG_AREA_HEIGHT   = 2'd1,
        CFG_CHUNK_LIMIT   = 2'd2,
        CFG_MOVE_INTERVAL = 2'd3
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [9:0]  AREA_WIDTH_RST    = 10'd789;
    localparam logic [9:0]  AREA_HEIGHT_RST   = 10'd532;
    localparam logic [11:0] CHUNK_LIMIT_RST   = 12'd500;
    localparam logic [15:0] MOVE_INTERVAL_RST = 16'd50;

    // Record geometry: code byte, time byte, up to three payload bytes
    localparam int REC_BYTES = 5;
    localparam int REC_IDX_W = $clog2(REC_BYTES);
    localparam int PAY_BYTES = REC_BYTES - 2;

    typedef logic [REC_IDX_W-1:0] t_len;

    typedef struct packed {
        logic [REC_BYTES-1:0][7:0] bytes;
        t_len                      len;
        logic                      rot;
    } t_rec;

    // Record queue between front and back end (power of two)
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

endpackage

/* rtl/iere_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iere_front
// Front end: accepts events, filters and classifies them against tracking
// state and configuration, then builds one complete record per kept event
// but an enable (time delta divided by ten, chunk rotation) and pushes it to the queue.
// ----------------------------------------------------------------------------
module iere_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // event input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [3:0]                          i_mode,
    input  logic [31:0]                         i_now_ticks,
    input  logic signed [11:0]                  i_x_pos,
    input  logic signed [11:0]                  i_y_pos,
    input  logic [2:0]                          i_button,
    input  logic [11:0]                         i_key_code,
    // configuration writes
    input  logic                                i_cfg_wr,
    input  logic [iere_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [iere_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // record queue write side
    output logic                                o_wr_valid,
    input  logic                                i_wr_ready,
    output iere_pkg::t_rec                      o_wr_rec
);

    // Record codes
    localparam logic [7:0] CODE_PRESS_PRI   = 8'd1;
    localparam logic [7:0] CODE_PRESS_SEC   = 8'd2;
    localparam logic [7:0] CODE_RELEASE_PRI = 8'd3;
    localparam logic [7:0] CODE_RELEASE_SEC = 8'd4;
    localparam logic [7:0] CODE_MOVE_SMALL  = 8'd5;
    localparam logic [7:0] CODE_MOVE_MID    = 8'd6;
    localparam logic [7:0] CODE_MOVE_ABS    = 8'd7;
    localparam logic [7:0] CODE_KEYDOWN     = 8'd8;
    localparam logic [7:0] CODE_KEYUP       = 8'd9;
    localparam logic [7:0] CODE_MODE_OFS    = 8'd3;

    localparam logic [2:0] BUTTON_PRIMARY   = 3'd1;

    // Record lengths
    localparam iere_pkg::t_len LEN_SHORT = 3'd2;
    localparam iere_pkg::t_len LEN_ONE   = 3'd3;
    localparam iere_pkg::t_len LEN_TWO   = 3'd4;
    localparam iere_pkg::t_len LEN_THREE = 3'd5;

    // Time delta: saturate at 250 units of ten ticks, divide by reciprocal
    localparam logic [11:0] DT_SAT_TICKS = 12'd2510;
    localparam logic [11:0] DT_CLIP      = 12'd2500;
    localparam logic [13:0] DIV10_MUL    = 14'd6554;
    localparam int          DIV10_SHIFT  = 16;

    // Key remap points
    localparam logic [11:0] KEY_A     = 12'd1000;
    localparam logic [11:0] KEY_B     = 12'd1001;
    localparam logic [11:0] KEY_C     = 12'd1002;
    localparam logic [11:0] KEY_D     = 12'd1003;
    localparam logic [11:0] KEY_HIGH  = 12'd1008;
    localparam logic [11:0] KEY_SHIFT = 12'd992;
    localparam logic [7:0]  KEY_A_MAP = 8'd11;
    localparam logic [7:0]  KEY_B_MAP = 8'd12;
    localparam logic [7:0]  KEY_C_MAP = 8'd14;
    localparam logic [7:0]  KEY_D_MAP = 8'd15;

    // Classified event held between the two front stages
    typedef struct packed {
        logic                                 clr;
        logic [7:0]                           code;
        logic [11:0]                          dt;
        iere_pkg::t_len                       len;
        logic [iere_pkg::PAY_BYTES-1:0][7:0]  pay;
    } t_s1;

    function automatic logic [7:0] f_remap(input logic [11:0] key);
        logic [11:0] k;
        begin
            k = key;
            if (key == KEY_A) begin
                k = {4'd0, KEY_A_MAP};
            end else if (key == KEY_B) begin
                k = {4'd0, KEY_B_MAP};
            end else if (key == KEY_C) begin
                k = {4'd0, KEY_C_MAP};
            end else if (key == KEY_D) begin
                k = {4'd0, KEY_D_MAP};
            end else if (key >= KEY_HIGH) begin
                k = key - KEY_SHIFT;
            end
            return k[7:0];
        end
    endfunction

    // Configuration registers
    logic [9:0]  r_area_w;
    logic [9:0]  r_area_h;
    logic [11:0] r_chunk_limit;
    logic [15:0] r_move_int;

    // Tracking state
    logic        r_tracking, n_tracking;
    logic [31:0] r_last_time, n_last_time;
    logic [31:0] r_last_move, n_last_move;
    logic [9:0]  r_last_x, n_last_x;
    logic [9:0]  r_last_y, n_last_y;
    logic [11:0] r_fill, n_fill;

    // Stage one register
    logic        r_s1_vld;
    t_s1         r_s1, n_s1;
    logic        c_keep;

    logic        in_acc;
    logic        s1_done;
    logic        in_area;
    logic [31:0] d_time;
    logic        dt_sat;
    logic [31:0] d_move;
    logic        move_due;
    logic [10:0] dx;
    logic [10:0] dy;
    logic        step_small;
    logic        step_mid;
    logic [7:0]  pos_hi;
    logic [7:0]  pos_mid;
    logic [7:0]  pos_lo;

    logic [25:0] s2_prod;
    logic [12:0] fill_sum;
    logic        rot;

    // Stage one advances when empty or when its event leaves
    assign s1_done    = r_s1_vld && (r_s1.clr || i_wr_ready);
    assign o_in_ready = !r_s1_vld || s1_done;
    assign in_acc     = i_in_valid && o_in_ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_w      <= iere_pkg::AREA_WIDTH_RST;
            r_area_h      <= iere_pkg::AREA_HEIGHT_RST;
            r_chunk_limit <= iere_pkg::CHUNK_LIMIT_RST;
            r_move_int    <= iere_pkg::MOVE_INTERVAL_RST;
        end else if (i_cfg_wr) begin
            case (iere_pkg::t_cfg_idx'(i_cfg_index))
                iere_pkg::CFG_AREA_WIDTH:    r_area_w      <= i_cfg_data[9:0];
                iere_pkg::CFG_AREA_HEIGHT:   r_area_h      <= i_cfg_data[9:0];
                iere_pkg::CFG_CHUNK_LIMIT:   r_chunk_limit <= i_cfg_data[11:0];
                iere_pkg::CFG_MOVE_INTERVAL: r_move_int    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Compute area, time and step checks of the incoming event
    always_comb begin
        in_area  = (i_x_pos[11:10] == 2'b00) && (i_x_pos[9:0] < r_area_w) &&
                   (i_y_pos[11:10] == 2'b00) && (i_y_pos[9:0] < r_area_h);
        d_time   = i_now_ticks - r_last_time;
        dt_sat   = (d_time[31:12] != '0) || (d_time[11:0] >= DT_SAT_TICKS);
        d_move   = i_now_ticks - r_last_move;
        move_due = !((d_move[31:16] == '0) && (d_move[15:0] < r_move_int));
        dx       = {1'b0, i_x_pos[9:0]} - {1'b0, r_last_x};
        dy       = {1'b0, i_y_pos[9:0]} - {1'b0, r_last_y};
        step_small = ((dx[10:3] == '0) || (dx[10:3] == '1)) &&
                     ((dy[10:3] == '0) || (dy[10:3] == '1));
        step_mid   = ((dx[10:7] == '0) || (dx[10:7] == '1)) &&
                     ((dy[10:7] == '0) || (dy[10:7] == '1));
        // absolute position x + 1024*y, big-endian
        pos_hi  = {4'd0, i_y_pos[9:6]};
        pos_mid = {i_y_pos[5:0], i_x_pos[9:8]};
        pos_lo  = i_x_pos[7:0];
    end

    // Classify event: decide whether it yields a record, update tracking state
    always_comb begin
        n_tracking  = r_tracking;
        n_last_time = r_last_time;
        n_last_move = r_last_move;
        n_last_x    = r_last_x;
        n_last_y    = r_last_y;
        c_keep      = 1'b0;
        n_s1.clr    = 1'b0;
        n_s1.code   = '0;
        n_s1.dt     = dt_sat ? DT_CLIP : d_time[11:0];
        n_s1.len    = LEN_SHORT;
        n_s1.pay    = '0;
        case (iere_pkg::t_mode'(i_mode))
            iere_pkg::MODE_ENABLE: begin
                n_tracking  = 1'b1;
                n_last_time = i_now_ticks;
                c_keep      = 1'b1;
                n_s1.clr    = 1'b1;
            end
            iere_pkg::MODE_DISABLE: begin
                n_tracking = 1'b0;
            end
            iere_pkg::MODE_PRESS: begin
                if (r_tracking && in_area) begin
                    c_keep      = 1'b1;
                    n_last_time = i_now_ticks;
                    n_s1.code   = (i_button == BUTTON_PRIMARY) ? CODE_PRESS_PRI
                                                                : CODE_PRESS_SEC;
                    n_s1.len    = LEN_THREE;
                    n_s1.pay    = {pos_lo, pos_mid, pos_hi};
                end
            end
            iere_pkg::MODE_RELEASE: begin
                if (r_tracking) begin
                    c_keep      = 1'b1;
                    n_last_time = i_now_ticks;
                    n_s1.code   = (i_button == BUTTON_PRIMARY) ? CODE_RELEASE_PRI
                                                                : CODE_RELEASE_SEC;
                end
            end
            iere_pkg::MODE_MOVE: begin
                if (r_tracking && in_area && move_due) begin
                    c_keep      = 1'b1;
                    n_last_time = i_now_ticks;
                    n_last_move = i_now_ticks;
                    n_last_x    = i_x_pos[9:0];
                    n_last_y    = i_y_pos[9:0];
                    if (step_small) begin
                        n_s1.code   = CODE_MOVE_SMALL;
                        n_s1.len    = LEN_ONE;
                        n_s1.pay[0] = {~dy[3], dy[2:0], ~dx[3], dx[2:0]};
                    end else if (step_mid) begin
                        n_s1.code   = CODE_MOVE_MID;
                        n_s1.len    = LEN_TWO;
                        n_s1.pay[0] = {~dx[7], dx[6:0]};
                        n_s1.pay[1] = {~dy[7], dy[6:0]};
                    end else begin
                        n_s1.code   = CODE_MOVE_ABS;
                        n_s1.len    = LEN_THREE;
                        n_s1.pay    = {pos_lo, pos_mid, pos_hi};
                    end
                end
            end
            iere_pkg::MODE_KEYDOWN,
            iere_pkg::MODE_KEYUP: begin
                if (r_tracking) begin
                    c_keep      = 1'b1;
                    n_last_time = i_now_ticks;
                    n_s1.code   = (iere_pkg::t_mode'(i_mode) == iere_pkg::MODE_KEYDOWN)
                                  ? CODE_KEYDOWN : CODE_KEYUP;
                    n_s1.len    = LEN_ONE;
                    n_s1.pay[0] = f_remap(i_key_code);
                end
            end
            iere_pkg::MODE_FOCUS_IN,
            iere_pkg::MODE_FOCUS_OUT,
            iere_pkg::MODE_ENTER,
            iere_pkg::MODE_EXIT: begin
                if (r_tracking) begin
                    c_keep      = 1'b1;
                    n_last_time = i_now_ticks;
                    n_s1.code   = {4'd0, i_mode} + CODE_MODE_OFS;
                end
            end
            default: ;
        endcase
    end

    // Update tracking state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking  <= 1'b0;
            r_last_time <= '0;
            r_last_move <= '0;
            r_last_x    <= '0;
            r_last_y    <= '0;
        end else if (in_acc) begin
            r_tracking  <= n_tracking;
            r_last_time <= n_last_time;
            r_last_move <= n_last_move;
            r_last_x    <= n_last_x;
            r_last_y    <= n_last_y;
        end
    end

    // Hold the classified event in stage one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= in_acc && c_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    // Stage two: divide delta by ten, decide chunk rotation, assemble record
    always_comb begin
        s2_prod  = 26'(r_s1.dt) * 26'(DIV10_MUL);
        fill_sum = {1'b0, r_fill} + 13'(r_s1.len);
        rot      = fill_sum >= {1'b0, r_chunk_limit};
        if (r_s1.clr) begin
            n_fill = '0;
        end else if (rot) begin
            n_fill = 12'(r_s1.len);
        end else begin
            n_fill = fill_sum[11:0];
        end
        o_wr_rec.bytes[0] = r_s1.code;
        o_wr_rec.bytes[1] = s2_prod[DIV10_SHIFT +: 8];
        for (int k = 0; k < iere_pkg::PAY_BYTES; k++) begin
            o_wr_rec.bytes[k + 2] = r_s1.pay[k];
        end
        o_wr_rec.len = r_s1.len;
        o_wr_rec.rot = rot;
    end

    assign o_wr_valid = r_s1_vld && !r_s1.clr;

    // Advance chunk fill when a record leaves or an enable passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (s1_done) begin
            r_fill <= n_fill;
        end
    end

endmodule

/* rtl/iere_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iere_fifo
// Short record queue between front and back end, so that either side can
// stall without holding the other.
// ----------------------------------------------------------------------------
module iere_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  iere_pkg::t_rec i_wr_rec,
    output logic           o_rd_valid,
    input  logic           i_rd_pop,
    output iere_pkg::t_rec o_rd_rec
);

    localparam int CNT_W = iere_pkg::FIFO_AW + 1;
    localparam logic [CNT_W-1:0]            CNT_FULL = CNT_W'(iere_pkg::FIFO_DEPTH);
    localparam logic [iere_pkg::FIFO_AW-1:0] PTR_LAST =
        iere_pkg::FIFO_AW'(iere_pkg::FIFO_DEPTH - 1);

    iere_pkg::t_rec                 r_mem [iere_pkg::FIFO_DEPTH];
    logic [iere_pkg::FIFO_AW-1:0]   r_wptr, n_wptr;
    logic [iere_pkg::FIFO_AW-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]               r_count, n_count;
    logic                           push;
    logic                           pop;

    assign o_wr_ready = (r_count != CNT_FULL);
    assign o_rd_valid = (r_count != '0);
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = i_rd_pop && o_rd_valid;
    assign o_rd_rec   = r_mem[r_rptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store pushed record
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_wr_rec;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("record queue occupancy above depth");

    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("record queue occupancy missed a push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wptr == r_rptr))
        else $error("record queue empty with pointers apart");

endmodule

/* rtl/iere_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iere_back
// Back end: takes records from the queue and sends them out one byte per
// transfer, flagging the chunk start and the final byte of each record.
// ----------------------------------------------------------------------------
module iere_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rd_valid,
    output logic           o_rd_pop,
    input  iere_pkg::t_rec i_rd_rec,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_data_byte,
    output logic           o_chunk_start,
    output logic           o_last
);

    logic           r_busy, n_busy;
    iere_pkg::t_rec r_rec;
    iere_pkg::t_len r_idx, n_idx;
    logic           cur_last;
    logic           out_acc;
    logic           done;
    logic           load;

    assign cur_last = (r_idx == r_rec.len - 1'b1);
    assign out_acc  = r_busy && i_out_ready;
    assign done     = out_acc && cur_last;
    assign load     = (!r_busy || done) && i_rd_valid;
    assign o_rd_pop = load;

    // Step through the bytes of the current record
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (load) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (done) begin
            n_busy = 1'b0;
        end else if (out_acc) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_rd_rec;
        end
    end

    // Drive the output byte from the held record
    assign o_out_valid   = r_busy;
    assign o_data_byte   = r_rec.bytes[r_idx];
    assign o_chunk_start = r_rec.rot && (r_idx == '0);
    assign o_last        = cur_last;

    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && i_rd_valid) |=> r_busy)
        else $error("gap between queued records");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_rec.len))
        else $error("byte index past record length");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !done) |-> !o_rd_pop)
        else $error("record taken while previous one still sending");

endmodule

/* rtl/input_event_record_encoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_event_record_encoder_core
// Encodes timestamped input events into compact byte records: a code byte,
// a time-delta byte and up to three payload bytes, sent one byte per transfer.
// ----------------------------------------------------------------------------
// Path: an accepted event is registered in the classify stage, its record is
//   built, written to the queue and loaded into the back end output register.
// Throughput: one event per cycle enters while the queue has room; records
//   leave at one byte per cycle while the output is ready, so a record takes
//   2 to 5 transfers at the byte-wide output.
// Reset: synchronous, active low; tracking off, times, position and chunk
//   fill cleared, registers at their defaults, no cleanup pass needed.
module input_event_record_encoder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // event input
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [3:0]                      i_mode,
    input  logic [31:0]                     i_now_ticks,
    input  logic signed [11:0]              i_x_pos,
    input  logic signed [11:0]              i_y_pos,
    input  logic [2:0]                      i_button,
    input  logic [11:0]                     i_key_code,
    // byte output
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_data_byte,
    output logic                            o_chunk_start,
    output logic                            o_last,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [iere_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [iere_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic           wr_valid;
    logic           wr_ready;
    iere_pkg::t_rec wr_rec;
    logic           rd_valid;
    logic           rd_pop;
    iere_pkg::t_rec rd_rec;

    // Take configuration writes at any time
    assign o_cfg_ready = 1'b1;

    iere_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_now_ticks (i_now_ticks),
        .i_x_pos     (i_x_pos),
        .i_y_pos     (i_y_pos),
        .i_button    (i_button),
        .i_key_code  (i_key_code),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_wr_valid  (wr_valid),
        .i_wr_ready  (wr_ready),
        .o_wr_rec    (wr_rec)
    );

    iere_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (wr_valid),
        .o_wr_ready (wr_ready),
        .i_wr_rec   (wr_rec),
        .o_rd_valid (rd_valid),
        .i_rd_pop   (rd_pop),
        .o_rd_rec   (rd_rec)
    );

    iere_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_valid    (rd_valid),
        .o_rd_pop      (rd_pop),
        .i_rd_rec      (rd_rec),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_byte   (o_data_byte),
        .o_chunk_start (o_chunk_start),
        .o_last        (o_last)
    );

endmodule
